[hw/rtl/inverse_cdf_table_sampler_unit_macros.svh]
// Assertion macros shared by the checker of the inverse CDF sampler.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef INVERSE_CDF_TABLE_SAMPLER_UNIT_MACROS_SVH
`define INVERSE_CDF_TABLE_SAMPLER_UNIT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ICDF_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define ICDF_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Implication that is checked during reset too.
`define ICDF_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

[hw/rtl/icdf_pkg.sv]
// Shared types and constants of the inverse CDF table sampler.
// Depends on nothing; imported by the search, divider and top-level modules.
package icdf_pkg;

    localparam int BINS    = 32;
    localparam int ENTRIES = BINS + 1;
    localparam int IDX_W   = 6;
    localparam int BIN_W   = $clog2(BINS);
    localparam int VAL_W   = 17;
    localparam int UNI_W   = 16;
    localparam int OUT_W   = 16;
    localparam int SPAN_W  = OUT_W + 1;
    localparam int A_W     = BIN_W + VAL_W + 2;
    localparam int P_W     = SPAN_W + A_W;
    localparam int NUM_W   = P_W - 1 - BIN_W;
    localparam int QW      = 18;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } icdf_op_t;

    typedef enum logic {
        CFG_LOWER = 1'b0,
        CFG_UPPER = 1'b1
    } icdf_cfg_idx_t;

    typedef struct packed {
        icdf_op_t          op;
        logic [IDX_W-1:0]  idx;
        logic [VAL_W-1:0]  val;
        logic [UNI_W-1:0]  r;
    } icdf_item_t;

    typedef struct packed {
        logic              valid;
        icdf_item_t        item;
        logic [BIN_W-1:0]  bin;
        logic [IDX_W-1:0]  bin_next;
    } icdf_search_t;

    typedef struct packed {
        logic neg;
        logic flat;
    } icdf_side_t;

endpackage

[hw/rtl/icdf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module icdf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 33
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/icdf_search.sv]
// Table search: keeps a copy of the cumulative table for parallel compares
// and finds the bin of each sample. Depends on icdf_pkg.
module icdf_search import icdf_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         en,
    input  logic         in_valid,
    input  icdf_item_t   in_item,
    output icdf_search_t out
);

    logic [VAL_W-1:0]   cmp_reg [ENTRIES];
    logic [ENTRIES-1:0] ge;
    logic [ENTRIES-1:0] ge_reg;
    logic               valid_reg;
    icdf_item_t         item_reg;
    logic [IDX_W-1:0]   pos;
    logic [IDX_W-1:0]   bin_w;

    // Compare every entry against the variate at once.
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            ge[i] = cmp_reg[i] >= VAL_W'(in_item.r);
        end
    end

    // Table copy is updated in item order as writes pass this stage.
    always_ff @(posedge aclk) begin
        if (en && in_valid && in_item.op == OP_WRITE && in_item.idx <= IDX_W'(BINS)) begin
            cmp_reg[in_item.idx] <= in_item.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= in_item;
            ge_reg   <= ge;
        end
    end

    // First entry at least r; no hit gives one past the end.
    always_comb begin
        pos = IDX_W'(ENTRIES);
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (ge_reg[i]) begin
                pos = IDX_W'(i);
            end
        end
        if (pos == '0) begin
            bin_w = '0;
        end else begin
            bin_w = pos - 1'b1;
        end
        if (bin_w > IDX_W'(BINS - 1)) begin
            bin_w = IDX_W'(BINS - 1);
        end
    end

    assign out.valid    = valid_reg;
    assign out.item     = item_reg;
    assign out.bin      = bin_w[BIN_W-1:0];
    assign out.bin_next = bin_w + 1'b1;

endmodule

[hw/rtl/icdf_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow
// detect for quotients beyond QW bits. Depends on icdf_pkg.
module icdf_divider import icdf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] in_num,
    input  logic [VAL_W-1:0] in_den,
    input  icdf_side_t       in_side,
    output logic             out_valid,
    output logic [QW-1:0]    out_quo,
    output logic             out_ovf,
    output icdf_side_t       out_side
);

    logic             vld_reg  [QW+1];
    logic [NUM_W-1:0] rem_reg  [QW+1];
    logic [VAL_W-1:0] den_reg  [QW+1];
    logic [QW-1:0]    quo_reg  [QW+1];
    logic             ovf_reg  [QW+1];
    icdf_side_t       side_reg [QW+1];
    logic [NUM_W:0]   limit;

    // Quotient would not fit in QW bits.
    assign limit = (NUM_W+1)'(in_den) << QW;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= in_num;
            den_reg[0]  <= in_den;
            quo_reg[0]  <= '0;
            ovf_reg[0]  <= {1'b0, in_num} >= limit;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [NUM_W-1:0] shifted;
        logic             take;

        // Trial subtract of the divisor at this bit weight.
        assign shifted = NUM_W'(den_reg[k]) << (QW - 1 - k);
        assign take    = rem_reg[k] >= shifted;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= take ? rem_reg[k] - shifted : rem_reg[k];
                quo_reg[k+1]  <= quo_reg[k] | (take ? QW'(1) << (QW - 1 - k) : '0);
                den_reg[k+1]  <= den_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = vld_reg[QW];
    assign out_quo   = quo_reg[QW];
    assign out_ovf   = ovf_reg[QW];
    assign out_side  = side_reg[QW];

endmodule

[hw/rtl/inverse_cdf_table_sampler_unit.sv]
// Channel   | Direction | Contents
// s_ (in)   | sink      | tuser: operation; tdata: entry_index, entry_value, uniform
// m_ (out)  | source    | tuser: flat_bin; tdata: value
// cfg_      | write     | lower_bound_q12 (0), upper_bound_q12 (1)
// One item enters per cycle while the output is not stalled. A sample passes six stages
// (capture, search, table read, bin width, position, multiply), the divider's input
// stage and 18 quotient stages, and the output register.
// Table writes give no result. Reset is synchronous, clears valid bits and returns the
// bounds to -5.0 and +5.0; table contents are undefined until written.
// A stall on the result side halts the whole pipeline, which holds every item.
// Top level of the inverse CDF sampler. Depends on icdf_pkg, icdf_search,
// icdf_ram and icdf_divider.
module inverse_cdf_table_sampler_unit import icdf_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // entry_index[5:0], entry_value[22:6], uniform[38:23]
    input  logic        s_tuser,   // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // value
    output logic        m_tuser,   // flat_bin
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    logic                     en;
    logic signed [OUT_W-1:0]  lower_reg;
    logic signed [OUT_W-1:0]  upper_reg;
    logic                     a_valid_reg;
    icdf_item_t               a_item_reg;
    icdf_search_t             srch;
    logic                     ram_we;
    logic [VAL_W-1:0]         c0_data;
    logic [VAL_W-1:0]         c1_data;
    logic                     c_valid_reg;
    logic [BIN_W-1:0]         c_bin_reg;
    logic [UNI_W-1:0]         c_r_reg;
    logic signed [VAL_W:0]    num_p, num_n, den_p, den_n;
    logic                     d_valid_reg;
    logic [BIN_W-1:0]         d_bin_reg;
    logic [VAL_W-1:0]         d_den_reg;
    logic signed [VAL_W:0]    d_num_reg;
    logic                     d_flat_reg;
    logic [BIN_W+VAL_W-1:0]   d_scaled;
    logic                     e_valid_reg;
    logic signed [A_W-1:0]    e_a_reg;
    logic signed [SPAN_W-1:0] e_span_reg;
    logic [VAL_W-1:0]         e_den_reg;
    logic                     e_flat_reg;
    logic                     f_valid_reg;
    logic signed [P_W-1:0]    f_prod_reg;
    logic [VAL_W-1:0]         f_den_reg;
    logic                     f_flat_reg;
    logic [P_W-1:0]           f_mag;
    icdf_side_t               f_side;
    logic                     q_valid;
    logic [QW-1:0]            q_quo;
    logic                     q_ovf;
    icdf_side_t               q_side;
    logic signed [QW:0]       q_mag;
    logic signed [QW+1:0]     q_off;
    logic signed [QW+2:0]     q_sum;
    logic                     m_valid_reg;
    logic [OUT_W-1:0]         m_data_reg;
    logic                     m_flat_reg;

    // The pipeline moves whenever the output slot is free or being taken.
    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // Bound registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= -16'sd20480;
            upper_reg <= 16'sd20480;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_LOWER: lower_reg <= cfg_wdata;
                CFG_UPPER: upper_reg <= cfg_wdata;
                default:   lower_reg <= lower_reg;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_item_reg.op  <= icdf_op_t'(s_tuser);
            a_item_reg.idx <= s_tdata[5:0];
            a_item_reg.val <= s_tdata[22:6];
            a_item_reg.r   <= s_tdata[38:23];
        end
    end

    icdf_search u_search (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (a_valid_reg),
        .in_item  (a_item_reg),
        .out      (srch)
    );

    // Two copies of the table give both bin edges in the same cycle.
    assign ram_we = en && srch.valid && srch.item.op == OP_WRITE
                    && srch.item.idx <= IDX_W'(BINS);

    icdf_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_ram_lo (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (srch.item.idx),
        .wdata (srch.item.val),
        .re    (en),
        .raddr (IDX_W'(srch.bin)),
        .rdata (c0_data)
    );

    icdf_ram #(.WIDTH(VAL_W), .DEPTH(ENTRIES)) u_ram_hi (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (srch.item.idx),
        .wdata (srch.item.val),
        .re    (en),
        .raddr (srch.bin_next),
        .rdata (c1_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en) begin
            c_valid_reg <= srch.valid && srch.item.op == OP_SAMPLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c_bin_reg <= srch.bin;
            c_r_reg   <= srch.item.r;
        end
    end

    // Bin width and offset, folded so that the width is never negative.
    assign num_p = $signed({2'b00, c_r_reg}) - $signed({1'b0, c0_data});
    assign num_n = $signed({1'b0, c0_data}) - $signed({2'b00, c_r_reg});
    assign den_p = $signed({1'b0, c1_data}) - $signed({1'b0, c0_data});
    assign den_n = $signed({1'b0, c0_data}) - $signed({1'b0, c1_data});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (en) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_bin_reg  <= c_bin_reg;
            d_flat_reg <= den_p == '0;
            if (den_p == '0) begin
                // A flat bin lands on its left edge: bin / BINS.
                d_den_reg <= VAL_W'(1);
                d_num_reg <= '0;
            end else if (den_p[VAL_W]) begin
                d_den_reg <= den_n[VAL_W-1:0];
                d_num_reg <= num_n;
            end else begin
                d_den_reg <= den_p[VAL_W-1:0];
                d_num_reg <= num_p;
            end
        end
    end

    // Position numerator bin * width + offset, and the output span.
    assign d_scaled = d_bin_reg * d_den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            e_a_reg    <= $signed({1'b0, d_scaled}) + A_W'(d_num_reg);
            e_span_reg <= SPAN_W'(upper_reg) - SPAN_W'(lower_reg);
            e_den_reg  <= d_den_reg;
            e_flat_reg <= d_flat_reg;
        end
    end

    // Span times position numerator.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (en) begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_prod_reg <= P_W'(e_span_reg) * P_W'(e_a_reg);
            f_den_reg  <= e_den_reg;
            f_flat_reg <= e_flat_reg;
        end
    end

    // Magnitude; dividing by BINS first is exact under truncation.
    assign f_mag       = f_prod_reg[P_W-1] ? P_W'(-f_prod_reg) : P_W'(f_prod_reg);
    assign f_side.neg  = f_prod_reg[P_W-1];
    assign f_side.flat = f_flat_reg;

    icdf_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid_reg),
        .in_num    (f_mag[P_W-2:BIN_W]),
        .in_den    (f_den_reg),
        .in_side   (f_side),
        .out_valid (q_valid),
        .out_quo   (q_quo),
        .out_ovf   (q_ovf),
        .out_side  (q_side)
    );

    // Signed offset, add the lower bound and saturate.
    assign q_mag = q_ovf ? $signed({1'b0, {QW{1'b1}}}) : $signed({1'b0, q_quo});
    assign q_off = q_side.neg ? -(QW+2)'(q_mag) : (QW+2)'(q_mag);
    assign q_sum = (QW+3)'(lower_reg) + (QW+3)'(q_off);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_flat_reg <= q_side.flat;
            if (q_sum > (QW+3)'(32767)) begin
                m_data_reg <= 16'h7FFF;
            end else if (q_sum < -(QW+3)'(32768)) begin
                m_data_reg <= 16'h8000;
            end else begin
                m_data_reg <= q_sum[OUT_W-1:0];
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_flat_reg;

endmodule

[hw/rtl/icdf_checker.sv]
// Port-level checks of the inverse CDF sampler, bound to the top level.
// Depends on inverse_cdf_table_sampler_unit_macros.svh.
`include "inverse_cdf_table_sampler_unit_macros.svh"

module icdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // A result that is not taken stays put.
    `ICDF_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result changed")

    // An empty output slot never blocks input.
    `ICDF_ASSERT_IMP(a_free, aclk, aresetn, !m_tvalid, s_tready, "input blocked with empty output")

    // A stalled output halts the input side.
    `ICDF_ASSERT_IMP(a_stall, aclk, aresetn, m_tvalid && !m_tready, !s_tready, "input taken during stall")

    // No result on the first cycle after reset is released.
    `ICDF_ASSERT_ALWAYS(a_reset, aclk, aresetn && $past(!aresetn), !m_tvalid, "result valid after reset")

endmodule

bind inverse_cdf_table_sampler_unit icdf_checker u_icdf_checker (.*);
